FILE: rtl/triangle_grid_binning_top_assert.svh
// Assertion macros for the triangle grid binning top module.
`ifndef TRIANGLE_GRID_BINNING_TOP_ASSERT_SVH
`define TRIANGLE_GRID_BINNING_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TGB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TGB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/tgb_pkg.sv
// Package with types and constants for the triangle grid binning block.
`timescale 1ns / 1ps
package tgb_pkg;

  localparam int COORD_W     = 32;
  localparam int LEN_W       = 31;
  localparam int ID_W        = 24;
  localparam int CELL_W      = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  // Origin plus up to 255 cell lengths, signed, without overflow.
  localparam int BOUND_W     = 40;
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = $clog2(MAX_RESULTS);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_LEN_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_LEN_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_LEN_Z = 3'd5;

  localparam logic [LEN_W-1:0] CELL_LEN_RESET = 31'd65536;

  typedef struct packed {
    logic signed [COORD_W-1:0] v0_x;
    logic signed [COORD_W-1:0] v0_y;
    logic signed [COORD_W-1:0] v0_z;
    logic signed [COORD_W-1:0] v1_x;
    logic signed [COORD_W-1:0] v1_y;
    logic signed [COORD_W-1:0] v1_z;
    logic signed [COORD_W-1:0] v2_x;
    logic signed [COORD_W-1:0] v2_y;
    logic signed [COORD_W-1:0] v2_z;
    logic [ID_W-1:0]           tri_id;
  } tri_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_i;
    logic [CELL_W-1:0] cell_j;
    logic [CELL_W-1:0] cell_k;
    logic [ID_W-1:0]   tri_tag;
    logic              hit;
    logic              last;
  } cell_t;

  // Bounding interval of the triangle on one axis.
  typedef struct packed {
    logic signed [COORD_W-1:0] lo;
    logic signed [COORD_W-1:0] hi;
  } box_t;

  // Result of one overlap test of a cell against the box.
  typedef struct packed {
    logic signed [BOUND_W-1:0] bound_next;
    logic                      hit;
  } span_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BOX,
    ST_SWEEP,
    ST_START,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

endpackage

FILE: rtl/tgb_stream_if.sv
// Valid/ready channel interfaces for triangles in and cells out.
`timescale 1ns / 1ps
interface tgb_tri_if;
  logic          valid;
  logic          ready;
  tgb_pkg::tri_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tgb_cell_if;
  logic           valid;
  logic           ready;
  tgb_pkg::cell_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/tgb_span_unit.sv
// Shared min/max, bound step and overlap compare unit for one axis.
`timescale 1ns / 1ps
module tgb_span_unit (
  input  logic signed [tgb_pkg::COORD_W-1:0] c0,
  input  logic signed [tgb_pkg::COORD_W-1:0] c1,
  input  logic signed [tgb_pkg::COORD_W-1:0] c2,
  input  logic signed [tgb_pkg::BOUND_W-1:0] bound,
  input  logic [tgb_pkg::LEN_W-1:0]          len,
  input  tgb_pkg::box_t                      box_in,
  output tgb_pkg::box_t                      box_out,
  output tgb_pkg::span_t                     span
);

  logic signed [tgb_pkg::COORD_W-1:0] lo01;
  logic signed [tgb_pkg::COORD_W-1:0] hi01;
  logic signed [tgb_pkg::BOUND_W-1:0] len_ext;
  logic signed [tgb_pkg::BOUND_W-1:0] lo_ext;
  logic signed [tgb_pkg::BOUND_W-1:0] hi_ext;

  // Minimum and maximum of the three vertex coordinates.
  always_comb begin
    lo01       = (c0 < c1) ? c0 : c1;
    hi01       = (c0 > c1) ? c0 : c1;
    box_out.lo = (lo01 < c2) ? lo01 : c2;
    box_out.hi = (hi01 > c2) ? hi01 : c2;
  end

  // Lower cell bound steps by one length; the cell overlaps unless it lies
  // wholly above or wholly below the box.
  always_comb begin
    len_ext         = $signed({{(tgb_pkg::BOUND_W - tgb_pkg::LEN_W){1'b0}}, len});
    lo_ext          = tgb_pkg::BOUND_W'(box_in.lo);
    hi_ext          = tgb_pkg::BOUND_W'(box_in.hi);
    span.bound_next = bound + len_ext;
    span.hit        = !(bound > hi_ext) && !(span.bound_next < lo_ext);
  end

endmodule

FILE: rtl/triangle_grid_binning_top.sv
// After a triangle is accepted, the sequencer runs BOX and SWEEP for x, y and z in turn, then START and EMIT.
// Each axis takes a box step and then sweeps its cells one by one in the shared compare unit.
// The next triangle is taken once the last of the R results (1 to 64) is in the output register.
// Results leave at one per cycle through the output register while the sink is ready.
// Synchronous active-high reset: idle, output empty, origins 0, cell lengths 1.0.
`timescale 1ns / 1ps
`include "triangle_grid_binning_top_assert.svh"
module triangle_grid_binning_top #(
  parameter int GRID_X = 4,
  parameter int GRID_Y = 4,
  parameter int GRID_Z = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tgb_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [tgb_pkg::CFG_DATA_W-1:0]    cfg_data,
  tgb_tri_if.sink                           tri_in,
  tgb_cell_if.source                        cell_out
);

  localparam int GMAX_XY = (GRID_X > GRID_Y) ? GRID_X : GRID_Y;
  localparam int GMAX    = (GMAX_XY > GRID_Z) ? GMAX_XY : GRID_Z;
  localparam int IW      = $clog2(GMAX + 1);

  // Configuration registers.
  logic signed [tgb_pkg::COORD_W-1:0] origin [3];
  logic [tgb_pkg::LEN_W-1:0]          cell_len [3];

  // Sequencer and datapath registers.
  tgb_pkg::state_t                    state;
  tgb_pkg::state_t                    state_next;
  tgb_pkg::axis_t                     axis;
  tgb_pkg::tri_t                      tri_q;
  tgb_pkg::box_t                      box_q;
  logic signed [tgb_pkg::BOUND_W-1:0] bound;
  logic [IW-1:0]                      n;
  logic                               found;
  logic [IW-1:0]                      first_idx [3];
  logic [IW-1:0]                      last_idx [3];
  logic [2:0]                         any_hit;
  logic [IW-1:0]                      ci;
  logic [IW-1:0]                      cj;
  logic [IW-1:0]                      ck;
  logic [tgb_pkg::CNT_W-1:0]          cnt;
  tgb_pkg::cell_t                     out_q;
  logic                               out_valid;

  // Combinational helpers.
  logic signed [tgb_pkg::COORD_W-1:0] c0;
  logic signed [tgb_pkg::COORD_W-1:0] c1;
  logic signed [tgb_pkg::COORD_W-1:0] c2;
  tgb_pkg::box_t                      box_new;
  tgb_pkg::span_t                     span;
  logic [IW-1:0]                      g_last;
  logic                               sweep_end;
  logic                               all_any;
  logic                               final_cell;
  logic                               cap;
  logic                               slot_free;
  logic                               done_emit;
  logic [IW+1:0]                      ci_ext;
  logic [IW+1:0]                      cj_ext;
  logic [IW+1:0]                      ck_ext;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin[0]   <= '0;
      origin[1]   <= '0;
      origin[2]   <= '0;
      cell_len[0] <= tgb_pkg::CELL_LEN_RESET;
      cell_len[1] <= tgb_pkg::CELL_LEN_RESET;
      cell_len[2] <= tgb_pkg::CELL_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        tgb_pkg::REG_ORIGIN_X:   origin[0]   <= cfg_data;
        tgb_pkg::REG_ORIGIN_Y:   origin[1]   <= cfg_data;
        tgb_pkg::REG_ORIGIN_Z:   origin[2]   <= cfg_data;
        tgb_pkg::REG_CELL_LEN_X: cell_len[0] <= cfg_data[tgb_pkg::LEN_W-1:0];
        tgb_pkg::REG_CELL_LEN_Y: cell_len[1] <= cfg_data[tgb_pkg::LEN_W-1:0];
        tgb_pkg::REG_CELL_LEN_Z: cell_len[2] <= cfg_data[tgb_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Vertex coordinates and last cell index of the axis in work.
  always_comb begin
    unique case (axis)
      tgb_pkg::AXIS_Y: begin
        c0     = tri_q.v0_y;
        c1     = tri_q.v1_y;
        c2     = tri_q.v2_y;
        g_last = IW'(GRID_Y - 1);
      end
      tgb_pkg::AXIS_Z: begin
        c0     = tri_q.v0_z;
        c1     = tri_q.v1_z;
        c2     = tri_q.v2_z;
        g_last = IW'(GRID_Z - 1);
      end
      default: begin
        c0     = tri_q.v0_x;
        c1     = tri_q.v1_x;
        c2     = tri_q.v2_x;
        g_last = IW'(GRID_X - 1);
      end
    endcase
  end

  tgb_span_unit u_span (
    .c0      (c0),
    .c1      (c1),
    .c2      (c2),
    .bound   (bound),
    .len     (cell_len[axis]),
    .box_in  (box_q),
    .box_out (box_new),
    .span    (span)
  );

  // Emission status.
  always_comb begin
    sweep_end  = (n == g_last);
    all_any    = &any_hit;
    final_cell = (ci == last_idx[0]) && (cj == last_idx[1]) && (ck == last_idx[2]);
    cap        = (cnt == tgb_pkg::CNT_W'(tgb_pkg::MAX_RESULTS - 1));
    slot_free  = !out_valid || cell_out.ready;
    done_emit  = slot_free && (!all_any || final_cell || cap);
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tgb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      tgb_pkg::ST_IDLE: begin
        if (tri_in.valid) state_next = tgb_pkg::ST_BOX;
      end
      tgb_pkg::ST_BOX: begin
        state_next = tgb_pkg::ST_SWEEP;
      end
      tgb_pkg::ST_SWEEP: begin
        if (sweep_end) begin
          state_next = (axis == tgb_pkg::AXIS_Z) ? tgb_pkg::ST_START : tgb_pkg::ST_BOX;
        end
      end
      tgb_pkg::ST_START: begin
        state_next = tgb_pkg::ST_EMIT;
      end
      tgb_pkg::ST_EMIT: begin
        if (done_emit) state_next = tgb_pkg::ST_IDLE;
      end
      default: state_next = tgb_pkg::ST_IDLE;
    endcase
  end

  // No triangle is taken while reset is held.
  assign tri_in.ready = (state == tgb_pkg::ST_IDLE) && !rst;

  // Datapath: box per axis, cell sweep, then i-j-k walk over the hit ranges or one miss item.
  always_ff @(posedge clk) begin
    case (state)
      tgb_pkg::ST_IDLE: begin
        if (tri_in.valid) begin
          tri_q <= tri_in.data;
          axis  <= tgb_pkg::AXIS_X;
        end
      end
      tgb_pkg::ST_BOX: begin
        box_q <= box_new;
        bound <= tgb_pkg::BOUND_W'(origin[axis]);
        n     <= '0;
        found <= 1'b0;
      end
      tgb_pkg::ST_SWEEP: begin
        if (span.hit) begin
          if (!found) first_idx[axis] <= n;
          last_idx[axis] <= n;
          found          <= 1'b1;
        end
        bound <= span.bound_next;
        n     <= n + IW'(1);
        if (sweep_end) begin
          any_hit[axis] <= found || span.hit;
          if (axis == tgb_pkg::AXIS_X) begin
            axis <= tgb_pkg::AXIS_Y;
          end else if (axis == tgb_pkg::AXIS_Y) begin
            axis <= tgb_pkg::AXIS_Z;
          end
        end
      end
      tgb_pkg::ST_START: begin
        ci  <= first_idx[0];
        cj  <= first_idx[1];
        ck  <= first_idx[2];
        cnt <= '0;
      end
      tgb_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_q.tri_tag <= tri_q.tri_id;
          if (all_any) begin
            out_q.cell_i <= ci_ext[tgb_pkg::CELL_W-1:0];
            out_q.cell_j <= cj_ext[tgb_pkg::CELL_W-1:0];
            out_q.cell_k <= ck_ext[tgb_pkg::CELL_W-1:0];
            out_q.hit    <= 1'b1;
            out_q.last   <= final_cell || cap;
            cnt          <= cnt + tgb_pkg::CNT_W'(1);
            if (ck == last_idx[2]) begin
              ck <= first_idx[2];
              if (cj == last_idx[1]) begin
                cj <= first_idx[1];
                ci <= ci + IW'(1);
              end else begin
                cj <= cj + IW'(1);
              end
            end else begin
              ck <= ck + IW'(1);
            end
          end else begin
            out_q.cell_i <= '0;
            out_q.cell_j <= '0;
            out_q.cell_k <= '0;
            out_q.hit    <= 1'b0;
            out_q.last   <= 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign ci_ext = {2'b00, ci};
  assign cj_ext = {2'b00, cj};
  assign ck_ext = {2'b00, ck};

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == tgb_pkg::ST_EMIT) && slot_free) begin
      out_valid <= 1'b1;
    end else if (cell_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign cell_out.valid = out_valid;
  assign cell_out.data  = out_q;

  // A miss result always closes the run for its triangle.
  `TGB_ASSERT_SAME(a_miss_is_last, cell_out.valid && !cell_out.data.hit, cell_out.data.last, "miss result without last")
  // Once a triangle is taken, no other is taken in the next cycle.
  `TGB_ASSERT_NEXT(a_busy_after_accept, tri_in.valid && tri_in.ready, !tri_in.ready, "accepted back to back")
  // The sweep counter never runs past the grid size of its axis.
  `TGB_ASSERT_SAME(a_sweep_in_grid, state == tgb_pkg::ST_SWEEP, n <= g_last, "sweep index out of grid")
  // The walk over x stays inside the hit range of x.
  `TGB_ASSERT_SAME(a_walk_in_range, (state == tgb_pkg::ST_EMIT) && all_any, (ci >= first_idx[0]) && (ci <= last_idx[0]), "cell walk left x range")

endmodule

FILE: tb/tb_triangle_grid_binning_top.sv
// Self-checking testbench for the triangle grid binning block.
`timescale 1ns / 1ps
module tb_triangle_grid_binning_top;

  localparam int GRID_X = 4;
  localparam int GRID_Y = 4;
  localparam int GRID_Z = 4;
  localparam int FILL_LATENCY = 5 + GRID_X + GRID_Y + GRID_Z;

  // Q16.16 helpers and coordinate extremes.
  localparam longint Q_ONE = 65536;
  localparam longint C_MIN = -64'sd2147483648;
  localparam longint C_MAX = 64'sd2147483647;

  // Indexes outside the register map; writes to them must change nothing.
  localparam logic [tgb_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [tgb_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [tgb_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [tgb_pkg::CFG_DATA_W-1:0] cfg_data;

  tgb_tri_if tri_ch ();
  tgb_cell_if cell_ch ();

  triangle_grid_binning_top #(
    .GRID_X(GRID_X),
    .GRID_Y(GRID_Y),
    .GRID_Z(GRID_Z)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data),
    .tri_in(tri_ch),
    .cell_out(cell_ch)
  );

  // Local copy of the grid registers, indexed by axis.
  longint grid_org[3];
  longint grid_len[3];

  // Cells still owed by the block, oldest first.
  tgb_pkg::cell_t cells_due[$];

  int error_count = 0;
  int tri_gap_pct = 0;
  int cell_stall_pct = 0;

  always #1 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("tb_triangle_grid_binning_top: done, errors");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic longint min3(input longint a, input longint b, input longint c);
    longint m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic longint max3(input longint a, input longint b, input longint c);
    longint m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic signed [tgb_pkg::COORD_W-1:0] clamp_coord(input longint v);
    if (v > C_MAX) begin
      return C_MAX[tgb_pkg::COORD_W-1:0];
    end
    if (v < C_MIN) begin
      return C_MIN[tgb_pkg::COORD_W-1:0];
    end
    return v[tgb_pkg::COORD_W-1:0];
  endfunction

  function automatic tgb_pkg::tri_t mk_tri(
      input longint ax, input longint ay, input longint az,
      input longint bx, input longint by, input longint bz,
      input longint cx, input longint cy, input longint cz,
      input logic [tgb_pkg::ID_W-1:0] id);
    tgb_pkg::tri_t t;
    t.v0_x = clamp_coord(ax);
    t.v0_y = clamp_coord(ay);
    t.v0_z = clamp_coord(az);
    t.v1_x = clamp_coord(bx);
    t.v1_y = clamp_coord(by);
    t.v1_z = clamp_coord(bz);
    t.v2_x = clamp_coord(cx);
    t.v2_y = clamp_coord(cy);
    t.v2_z = clamp_coord(cz);
    t.tri_id = id;
    return t;
  endfunction

  // Closed-interval overlap of cell n on one axis with the box [lo, hi].
  function automatic bit cell_overlaps(input int ax, input int n,
                                       input longint lo, input longint hi);
    longint c0;
    longint c1;
    c0 = grid_org[ax] + grid_len[ax] * n;
    c1 = grid_org[ax] + grid_len[ax] * (n + 1);
    return !(c0 > hi || c1 < lo);
  endfunction

  // Work out every cell the triangle's bounding box touches, k innermost.
  task automatic bin_triangle(input tgb_pkg::tri_t t);
    longint lo[3];
    longint hi[3];
    tgb_pkg::cell_t c;
    int hits;
    hits = 0;
    lo[0] = min3(t.v0_x, t.v1_x, t.v2_x);
    hi[0] = max3(t.v0_x, t.v1_x, t.v2_x);
    lo[1] = min3(t.v0_y, t.v1_y, t.v2_y);
    hi[1] = max3(t.v0_y, t.v1_y, t.v2_y);
    lo[2] = min3(t.v0_z, t.v1_z, t.v2_z);
    hi[2] = max3(t.v0_z, t.v1_z, t.v2_z);
    for (int i = 0; i < GRID_X; i++) begin
      if (!cell_overlaps(0, i, lo[0], hi[0])) continue;
      for (int j = 0; j < GRID_Y; j++) begin
        if (!cell_overlaps(1, j, lo[1], hi[1])) continue;
        for (int k = 0; k < GRID_Z; k++) begin
          if (!cell_overlaps(2, k, lo[2], hi[2])) continue;
          if (hits < tgb_pkg::MAX_RESULTS) begin
            c.cell_i = i[tgb_pkg::CELL_W-1:0];
            c.cell_j = j[tgb_pkg::CELL_W-1:0];
            c.cell_k = k[tgb_pkg::CELL_W-1:0];
            c.tri_tag = t.tri_id;
            c.hit = 1'b1;
            c.last = 1'b0;
            cells_due.push_back(c);
            hits++;
          end
        end
      end
    end
    // A triangle that misses the grid still produces one item.
    if (hits == 0) begin
      c = '0;
      c.tri_tag = t.tri_id;
      c.last = 1'b1;
      cells_due.push_back(c);
    end else begin
      cells_due[cells_due.size() - 1].last = 1'b1;
    end
  endtask

  // Register write; the local copy follows the same masking as the block.
  task automatic write_reg(input logic [tgb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tgb_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      tgb_pkg::REG_ORIGIN_X: grid_org[0] = $signed(data);
      tgb_pkg::REG_ORIGIN_Y: grid_org[1] = $signed(data);
      tgb_pkg::REG_ORIGIN_Z: grid_org[2] = $signed(data);
      tgb_pkg::REG_CELL_LEN_X: grid_len[0] = longint'(data[tgb_pkg::LEN_W-1:0]);
      tgb_pkg::REG_CELL_LEN_Y: grid_len[1] = longint'(data[tgb_pkg::LEN_W-1:0]);
      tgb_pkg::REG_CELL_LEN_Z: grid_len[2] = longint'(data[tgb_pkg::LEN_W-1:0]);
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one triangle, wait for it to be taken, then maybe leave a gap.
  task automatic send_tri(input tgb_pkg::tri_t t);
    tri_ch.valid <= 1'b1;
    tri_ch.data <= t;
    do @(posedge clk); while (!tri_ch.ready);
    bin_triangle(t);
    if ($urandom_range(0, 99) < tri_gap_pct) begin
      tri_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tri_gap_pct);
    end
  endtask

  // Stop sending and wait until every owed cell has come out.
  task automatic drain_cells();
    tri_ch.valid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Grid at reset: origin 0, unit cells, so the grid spans [0, 4] on each axis.
  task automatic test_grid_overlap();
    longint h;
    h = Q_ONE / 2;
    send_tri(mk_tri(h, h, h, h, h, h, h, h, h, 24'h000001));
    send_tri(mk_tri(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 24'h000000));
    send_tri(mk_tri(-Q_ONE, -Q_ONE, -Q_ONE, 5 * Q_ONE, 5 * Q_ONE, 5 * Q_ONE,
                    2 * Q_ONE, -Q_ONE, 5 * Q_ONE, 24'hFFFFFF));
    send_tri(mk_tri(4 * Q_ONE, 4 * Q_ONE, 4 * Q_ONE, 4 * Q_ONE, 4 * Q_ONE, 4 * Q_ONE,
                    4 * Q_ONE, 4 * Q_ONE, 4 * Q_ONE, 24'h000004));
    // Just past the far face and just before the near face: no overlap.
    send_tri(mk_tri(4 * Q_ONE + 1, h, h, 4 * Q_ONE + 1, h, h, 5 * Q_ONE, h, h, 24'h000005));
    send_tri(mk_tri(-1, -1, -1, -1, -1, -1, -Q_ONE, -1, -1, 24'h000006));
    // Flat slab across the whole x-y plane.
    send_tri(mk_tri(-Q_ONE, -Q_ONE, 5 * h, 5 * Q_ONE, 0, 5 * h, 0, 5 * Q_ONE, 5 * h, 24'h000007));
    // Overlaps on x and y but not z.
    send_tri(mk_tri(h, h, 10 * Q_ONE, 3 * Q_ONE, 3 * Q_ONE, 10 * Q_ONE,
                    h, h, 11 * Q_ONE, 24'h000008));
    drain_cells();
  endtask

  // Vertices at the ends of the coordinate range.
  task automatic test_coord_extremes();
    send_tri(mk_tri(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 24'h800000));
    send_tri(mk_tri(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 24'h7FFFFF));
    send_tri(mk_tri(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 0, 0, 0, 24'hA5A5A5));
    send_tri(mk_tri(C_MIN, Q_ONE / 2, Q_ONE / 2, C_MAX, Q_ONE / 2, Q_ONE / 2,
                    0, Q_ONE / 2, Q_ONE / 2, 24'h5A5A5A));
    drain_cells();
  endtask

  // Zero-length cells collapse onto the origin point of that axis.
  task automatic test_zero_length();
    write_reg(tgb_pkg::REG_ORIGIN_X, 32'(2 * Q_ONE));
    write_reg(tgb_pkg::REG_CELL_LEN_X, 32'd0);
    send_tri(mk_tri(Q_ONE, Q_ONE / 2, Q_ONE / 2, 3 * Q_ONE, Q_ONE / 2, Q_ONE / 2,
                    2 * Q_ONE, Q_ONE / 2, Q_ONE / 2, 24'h000010));
    send_tri(mk_tri(5 * Q_ONE / 2, 0, 0, 3 * Q_ONE, 0, 0, 3 * Q_ONE, 0, 0, 24'h000011));
    drain_cells();
    write_reg(tgb_pkg::REG_ORIGIN_Y, 32'(-Q_ONE));
    write_reg(tgb_pkg::REG_ORIGIN_Z, 32'h8000_0000);
    write_reg(tgb_pkg::REG_CELL_LEN_Y, 32'd0);
    write_reg(tgb_pkg::REG_CELL_LEN_Z, 32'd0);
    send_tri(mk_tri(2 * Q_ONE, -Q_ONE, C_MIN, 2 * Q_ONE, -Q_ONE, C_MIN,
                    2 * Q_ONE, -Q_ONE, C_MIN, 24'h000012));
    drain_cells();
  endtask

  // Largest origins and lengths, unmapped indexes, and the spare length bit.
  task automatic test_register_edges();
    write_reg(tgb_pkg::REG_ORIGIN_X, 32'h7FFF_FFFF);
    write_reg(tgb_pkg::REG_ORIGIN_Y, 32'h7FFF_FFFF);
    write_reg(tgb_pkg::REG_ORIGIN_Z, 32'h7FFF_FFFF);
    write_reg(tgb_pkg::REG_CELL_LEN_X, 32'hFFFF_FFFF);
    write_reg(tgb_pkg::REG_CELL_LEN_Y, 32'h7FFF_FFFF);
    write_reg(tgb_pkg::REG_CELL_LEN_Z, 32'h7FFF_FFFF);
    send_tri(mk_tri(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 24'h000020));
    send_tri(mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 24'h000021));
    drain_cells();
    write_reg(tgb_pkg::REG_ORIGIN_X, 32'h8000_0000);
    write_reg(tgb_pkg::REG_ORIGIN_Y, 32'h8000_0000);
    write_reg(tgb_pkg::REG_ORIGIN_Z, 32'h8000_0000);
    send_tri(mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 24'h000022));
    send_tri(mk_tri(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 24'h000023));
    send_tri(mk_tri(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 24'h000024));
    drain_cells();
    write_reg(REG_SPARE_6, $urandom);
    write_reg(REG_SPARE_7, $urandom);
    write_reg(tgb_pkg::REG_CELL_LEN_X, 32'h8001_0000);
    send_tri(mk_tri(0, 0, 0, Q_ONE, 0, 0, 0, 0, 0, 24'h000025));
    drain_cells();
  endtask

  // Random grid setting: mostly small cells near a modest origin.
  task automatic pick_grid();
    logic [tgb_pkg::CFG_DATA_W-1:0] org[3];
    logic [tgb_pkg::CFG_DATA_W-1:0] len[3];
    for (int ax = 0; ax < 3; ax++) begin
      case ($urandom_range(0, 9))
        0: org[ax] = 32'h8000_0000;
        1: org[ax] = 32'h7FFF_FFFF;
        2, 3, 4: org[ax] = $urandom;
        default: org[ax] = 32'($signed($urandom_range(0, 16 * Q_ONE)) - 8 * Q_ONE);
      endcase
      case ($urandom_range(0, 9))
        0: len[ax] = 32'd0;
        1: len[ax] = 32'h7FFF_FFFF;
        2: len[ax] = $urandom;
        default: len[ax] = 32'($urandom_range(1, 4 * Q_ONE));
      endcase
      len[ax][tgb_pkg::CFG_DATA_W-1] = 1'($urandom_range(0, 1));
    end
    write_reg(tgb_pkg::REG_ORIGIN_X, org[0]);
    write_reg(tgb_pkg::REG_ORIGIN_Y, org[1]);
    write_reg(tgb_pkg::REG_ORIGIN_Z, org[2]);
    write_reg(tgb_pkg::REG_CELL_LEN_X, len[0]);
    write_reg(tgb_pkg::REG_CELL_LEN_Y, len[1]);
    write_reg(tgb_pkg::REG_CELL_LEN_Z, len[2]);
  endtask

  // Triangle placed around the current grid, a fraction of a few cells in size.
  function automatic tgb_pkg::tri_t mesh_tri();
    longint base[3];
    longint spread[3];
    longint vc[9];
    for (int ax = 0; ax < 3; ax++) begin
      base[ax] = grid_org[ax] - grid_len[ax] / 2 +
                 (longint'($urandom_range(0, 1023)) * (5 * grid_len[ax])) / 1024;
      spread[ax] = grid_len[ax] * $urandom_range(0, 4) / 2;
    end
    for (int a = 0; a < 9; a++) begin
      vc[a] = base[a % 3] + (longint'($urandom_range(0, 1023)) * spread[a % 3]) / 1024;
    end
    return mk_tri(vc[0], vc[1], vc[2], vc[3], vc[4], vc[5], vc[6], vc[7], vc[8], 24'($urandom));
  endfunction

  // Fully random vertices, which mostly miss the grid.
  function automatic tgb_pkg::tri_t noise_tri();
    tgb_pkg::tri_t t;
    t.v0_x = $urandom;
    t.v0_y = $urandom;
    t.v0_z = $urandom;
    t.v1_x = $urandom;
    t.v1_y = $urandom;
    t.v1_z = $urandom;
    t.v2_x = $urandom;
    t.v2_y = $urandom;
    t.v2_z = $urandom;
    t.tri_id = 24'($urandom);
    return t;
  endfunction

  // Random triangles over several random grid settings.
  task automatic test_random_mesh(input int settings, input int per_setting);
    for (int s = 0; s < settings; s++) begin
      pick_grid();
      for (int n = 0; n < per_setting; n++) begin
        if ($urandom_range(0, 99) < 85) begin
          send_tri(mesh_tri());
        end else begin
          send_tri(noise_tri());
        end
      end
      drain_cells();
    end
  endtask

  // Receiver stalls at random.
  always @(posedge clk) begin
    if (rst) begin
      cell_ch.ready <= 1'b0;
    end else begin
      cell_ch.ready <= ($urandom_range(0, 99) >= cell_stall_pct);
    end
  end

  // Compare each cell item that leaves the block with the oldest owed cell.
  always @(posedge clk) begin : check_cells
    tgb_pkg::cell_t got;
    tgb_pkg::cell_t want;
    string bad;
    if (!rst && cell_ch.valid === 1'b1 && cell_ch.ready === 1'b1) begin
      got = cell_ch.data;
      if (cells_due.size() == 0) begin
        report_mismatch($sformatf("unexpected item tag %h i%0d j%0d k%0d hit %b last %b",
                                  got.tri_tag, got.cell_i, got.cell_j, got.cell_k,
                                  got.hit, got.last));
      end else begin
        want = cells_due.pop_front();
        bad = "";
        if (got.cell_i !== want.cell_i) bad = {bad, " cell_i"};
        if (got.cell_j !== want.cell_j) bad = {bad, " cell_j"};
        if (got.cell_k !== want.cell_k) bad = {bad, " cell_k"};
        if (got.tri_tag !== want.tri_tag) bad = {bad, " tri_tag"};
        if (got.hit !== want.hit) bad = {bad, " hit"};
        if (got.last !== want.last) bad = {bad, " last"};
        if (bad != "") begin
          report_mismatch({
              $sformatf("bad%s: got tag %h i%0d j%0d k%0d hit %b last %b",
                        bad, got.tri_tag, got.cell_i, got.cell_j, got.cell_k,
                        got.hit, got.last),
              $sformatf(", want tag %h i%0d j%0d k%0d hit %b last %b",
                        want.tri_tag, want.cell_i, want.cell_j, want.cell_k,
                        want.hit, want.last)});
        end
      end
    end
  end

  // Main sequence.
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    tri_ch.valid = 1'b0;
    tri_ch.data = '0;
    cell_ch.ready = 1'b0;
    for (int ax = 0; ax < 3; ax++) begin
      grid_org[ax] = 0;
      grid_len[ax] = longint'(tgb_pkg::CELL_LEN_RESET);
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Sender idles lightly, receiver heavily.
    tri_gap_pct = 20;
    cell_stall_pct = 49;
    test_grid_overlap();
    test_coord_extremes();
    test_zero_length();
    test_register_edges();
    test_random_mesh(3, 40);

    // Roles swapped.
    tri_gap_pct = 49;
    cell_stall_pct = 20;
    test_random_mesh(3, 40);

    // Full speed on both sides.
    tri_gap_pct = 0;
    cell_stall_pct = 0;
    test_random_mesh(3, 40);

    drain_cells();
    repeat (2 * FILL_LATENCY) @(posedge clk);
    if (cells_due.size() != 0) begin
      report_mismatch($sformatf("%0d cell items never arrived", cells_due.size()));
    end
    if (error_count == 0) begin
      $display("tb_triangle_grid_binning_top: done, clean");
    end else begin
      $display("tb_triangle_grid_binning_top: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/tgb_pkg.sv
rtl/tgb_stream_if.sv
rtl/tgb_span_unit.sv
rtl/triangle_grid_binning_top.sv
tb/tb_triangle_grid_binning_top.sv
